[hdl/srt_pkg.sv]
// Shared constants of the spin relaxation torque datapath.
// Fixed field widths, product cap, output limits and root pipeline sizing; no dependencies.
package srt_pkg;

  localparam int M_W    = 18;   // magnetization component, Q2.F
  localparam int H_W    = 32;   // effective field component
  localparam int OUT_W  = 40;   // rate component
  localparam int E_W    = 30;   // normalized |d| component fed to the squares
  localparam int SUM_W  = 62;   // sum of three squares
  localparam int R_W    = 31;   // integer root of SUM_W bits
  localparam int SQ_PER = 2;    // root bits resolved per pipeline stage
  localparam int CAP_W  = 62;   // magnitude of a capped product
  localparam int V_W    = 64;   // rate before saturation

  localparam logic [CAP_W-1:0] PROD_CAP = 62'h3FFF_FFFF_FFFF_FFFF;

  localparam logic signed [V_W-1:0] OUT_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [V_W-1:0] OUT_MIN = 64'shFFFF_FF80_0000_0000;

endpackage

[hdl/spin_relaxation_torque.sv]
// Spin relaxation torque: d = mm*h - mh*m plus the length correction 6*|d|*(1-mm)*m.
// Uses srt_pkg for field widths, the product cap and the integer root sizing.
// Throughput: one request per cycle; busy is low except during reset.
// The depth is set by the integer root: 31 root bits, two per stage, 16 stages.
// Reset: rst (synchronous) empties the valid line; requests in flight are dropped.
module spin_relaxation_torque #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [srt_pkg::M_W-1:0]    mag_x,
  input  logic signed [srt_pkg::M_W-1:0]    mag_y,
  input  logic signed [srt_pkg::M_W-1:0]    mag_z,
  input  logic signed [srt_pkg::H_W-1:0]    field_x,
  input  logic signed [srt_pkg::H_W-1:0]    field_y,
  input  logic signed [srt_pkg::H_W-1:0]    field_z,
  input  logic                              pinned,
  input  logic                              last_spin,
  output logic                              done,
  output logic signed [srt_pkg::OUT_W-1:0]  rate_x,
  output logic signed [srt_pkg::OUT_W-1:0]  rate_y,
  output logic signed [srt_pkg::OUT_W-1:0]  rate_z,
  output logic                              last_out
);

  localparam int M_W    = srt_pkg::M_W;
  localparam int H_W    = srt_pkg::H_W;
  localparam int OUT_W  = srt_pkg::OUT_W;
  localparam int E_W    = srt_pkg::E_W;
  localparam int SUM_W  = srt_pkg::SUM_W;
  localparam int R_W    = srt_pkg::R_W;
  localparam int SQ_PER = srt_pkg::SQ_PER;
  localparam int CAP_W  = srt_pkg::CAP_W;
  localparam int V_W    = srt_pkg::V_W;

  // datapath widths, sized for the worst case at this FRAC_BITS
  localparam int SQM_W = 2 * M_W;
  localparam int PMH_W = M_W + H_W;
  localparam int PM_W  = 35 - FRAC_BITS;
  localparam int PH_W  = 50 - FRAC_BITS;
  localparam int MMU_W = 36 - FRAC_BITS;
  localparam int MH_W  = 51 - FRAC_BITS;
  localparam int P1_W  = MMU_W + H_W;
  localparam int P2_W  = MH_W + M_W;
  localparam int P_W   = 68 - 2 * FRAC_BITS;
  localparam int D_W   = 69 - 2 * FRAC_BITS;
  localparam int DM_W  = 68 - 2 * FRAC_BITS;
  localparam int WM_W  = (FRAC_BITS + 1 > MMU_W) ? FRAC_BITS + 1 : MMU_W;
  localparam int T_MAX = (DM_W > E_W) ? DM_W - E_W : 1;
  localparam int T_W   = $clog2(T_MAX + 1);
  localparam int SQE_W = 2 * E_W;
  localparam int REM_W = R_W + 3;
  localparam int SQ_ST = (R_W + SQ_PER - 1) / SQ_PER;
  localparam int NORM_W = R_W + T_MAX;
  localparam int C_W   = NORM_W + 3;
  localparam int CL_W  = C_W / 2;
  localparam int CH_W  = C_W - CL_W;
  localparam int PKL_W = CL_W + WM_W;
  localparam int PKH_W = CH_W + WM_W;
  localparam int KF_W  = C_W + WM_W;
  localparam int KS_W  = KF_W - FRAC_BITS;
  localparam int KC_W  = (KS_W > CAP_W) ? KS_W : CAP_W;
  localparam int KL_W  = CAP_W / 2;
  localparam int KH_W  = CAP_W - KL_W;
  localparam int CLM_W = KL_W + M_W;
  localparam int CHM_W = KH_W + M_W;
  localparam int CF_W  = CAP_W + M_W;
  localparam int CS_W  = CF_W - FRAC_BITS;
  localparam int CC_W  = (CS_W > CAP_W) ? CS_W : CAP_W;
  localparam int CR_W  = CAP_W + 1;

  // stage numbers, in pipeline order: stage 1 is the register loaded by the
  // edge that takes the request
  localparam int S_PROD = 1;
  localparam int S_SUM  = 2;
  localparam int S_MUL2 = 3;
  localparam int S_D    = 4;
  localparam int S_ABS  = 5;
  localparam int S_MX1  = 6;
  localparam int S_MX   = 7;
  localparam int S_T    = 8;
  localparam int S_E    = 9;
  localparam int S_SQ   = 10;
  localparam int S_SUM2 = 11;
  localparam int S_RT0  = S_SUM2 + 1;
  localparam int S_RTN  = S_SUM2 + SQ_ST;
  localparam int S_NORM = S_RTN + 1;
  localparam int S_C    = S_RTN + 2;
  localparam int S_KP   = S_RTN + 3;
  localparam int S_KF   = S_RTN + 4;
  localparam int S_K    = S_RTN + 5;
  localparam int S_CP   = S_RTN + 6;
  localparam int S_CF   = S_RTN + 7;
  localparam int S_CR   = S_RTN + 8;
  localparam int S_V    = S_RTN + 9;
  localparam int S_OUT  = S_RTN + 10;

  // control and carried payload lines
  logic                     vld   [S_PROD:S_OUT];
  logic                     lst   [S_PROD:S_OUT];
  logic signed [M_W-1:0]    m_ln  [S_PROD:S_CF][3];
  logic signed [H_W-1:0]    h_ln  [S_PROD:S_SUM][3];
  logic signed [D_W-1:0]    d_ln  [S_D:S_CR][3];
  logic [DM_W-1:0]          dm_ln [S_ABS:S_T][3];
  logic [T_W-1:0]           t_ln  [S_T:S_RTN];
  logic [WM_W-1:0]          wm_ln [S_MUL2:S_C];
  logic                     wn_ln [S_MUL2:S_KF];
  logic                     kn_ln [S_K:S_CF];

  // stage registers
  logic [PM_W-1:0]          pm [3];
  logic signed [PH_W-1:0]   ph [3];
  logic [MMU_W-1:0]         mm;
  logic signed [MH_W-1:0]   mh;
  logic signed [P_W-1:0]    p1 [3];
  logic signed [P_W-1:0]    p2 [3];
  logic [DM_W-1:0]          mx01;
  logic [DM_W-1:0]          mx;
  logic [E_W-1:0]           e [3];
  logic [SQE_W-1:0]         sq [3];
  logic [SUM_W-1:0]         rt_n [S_SUM2:S_RTN];
  logic [REM_W-1:0]         rt_r [S_SUM2:S_RTN];
  logic [R_W-1:0]           rt_q [S_SUM2:S_RTN];
  logic [NORM_W-1:0]        norm;
  logic [C_W-1:0]           c;
  logic [PKL_W-1:0]         pk_lo;
  logic [PKH_W-1:0]         pk_hi;
  logic [KF_W-1:0]          kf;
  logic [CAP_W-1:0]         kmag;
  logic [CLM_W-1:0]         cl [3];
  logic [CHM_W-1:0]         ch [3];
  logic [CF_W-1:0]          cf [3];
  logic signed [CR_W-1:0]   corr [3];
  logic signed [V_W-1:0]    v [3];

  // next values
  logic signed [M_W-1:0]    m_next [3];
  logic signed [H_W-1:0]    h_next [3];
  logic [PM_W-1:0]          pm_next [3];
  logic signed [PH_W-1:0]   ph_next [3];
  logic signed [P_W-1:0]    p1_next [3];
  logic signed [P_W-1:0]    p2_next [3];
  logic [WM_W-1:0]          wm_next;
  logic                     wn_next;
  logic [DM_W-1:0]          dm_next [3];
  logic [T_W-1:0]           t_next;
  logic [SUM_W-1:0]         rt_n_next [S_RT0:S_RTN];
  logic [REM_W-1:0]         rt_r_next [S_RT0:S_RTN];
  logic [R_W-1:0]           rt_q_next [S_RT0:S_RTN];
  logic [CAP_W-1:0]         kmag_next;
  logic [CLM_W-1:0]         cl_next [3];
  logic [CHM_W-1:0]         ch_next [3];
  logic signed [CR_W-1:0]   corr_next [3];
  logic signed [OUT_W-1:0]  rate_next [3];

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // a pinned spin enters as all zeros, which drives every term to zero
  always_comb begin
    m_next[0] = pinned ? '0 : mag_x;
    m_next[1] = pinned ? '0 : mag_y;
    m_next[2] = pinned ? '0 : mag_z;
    h_next[0] = pinned ? '0 : field_x;
    h_next[1] = pinned ? '0 : field_y;
    h_next[2] = pinned ? '0 : field_z;
  end

  // stage 1: m_i*m_i and m_i*h_i, rounded half away from zero
  always_comb begin
    logic [M_W-1:0]   am;
    logic [H_W-1:0]   ah;
    logic [SQM_W-1:0] sqm;
    logic [PMH_W-1:0] pmh;
    logic [PH_W-1:0]  phm;
    for (int i = 0; i < 3; i++) begin
      am  = m_next[i][M_W-1] ? M_W'(-m_next[i]) : M_W'(m_next[i]);
      ah  = h_next[i][H_W-1] ? H_W'(-h_next[i]) : H_W'(h_next[i]);
      sqm = am * am;
      pmh = am * ah;
      pm_next[i] = PM_W'((sqm + (SQM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      phm = PH_W'((pmh + (PMH_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      ph_next[i] = (m_next[i][M_W-1] ^ h_next[i][H_W-1]) ? -phm : phm;
    end
  end

  // stage 3: mm*h_i and mh*m_i, and w = 1 - mm as sign and magnitude
  always_comb begin
    logic [M_W-1:0]  am;
    logic [H_W-1:0]  ah;
    logic [MH_W-1:0] amh;
    logic [P1_W-1:0] p1m;
    logic [P2_W-1:0] p2m;
    logic [P_W-1:0]  r1;
    logic [P_W-1:0]  r2;
    logic [WM_W-1:0] wone;
    logic [WM_W-1:0] mmw;
    amh = mh[MH_W-1] ? MH_W'(-mh) : MH_W'(mh);
    for (int i = 0; i < 3; i++) begin
      am  = m_ln[S_SUM][i][M_W-1] ? M_W'(-m_ln[S_SUM][i]) : M_W'(m_ln[S_SUM][i]);
      ah  = h_ln[S_SUM][i][H_W-1] ? H_W'(-h_ln[S_SUM][i]) : H_W'(h_ln[S_SUM][i]);
      p1m = P1_W'(mm) * P1_W'(ah);
      p2m = P2_W'(amh) * P2_W'(am);
      r1  = P_W'((p1m + (P1_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      r2  = P_W'((p2m + (P2_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      p1_next[i] = h_ln[S_SUM][i][H_W-1] ? -r1 : r1;
      p2_next[i] = (mh[MH_W-1] ^ m_ln[S_SUM][i][M_W-1]) ? -r2 : r2;
    end
    wone = WM_W'(1) << FRAC_BITS;
    mmw  = WM_W'(mm);
    if (mmw > wone) begin
      wm_next = mmw - wone;
      wn_next = 1'b1;
    end else begin
      wm_next = wone - mmw;
      wn_next = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm_next[i] = d_ln[S_D][i][D_W-1] ? DM_W'(-d_ln[S_D][i]) : DM_W'(d_ln[S_D][i]);
    end
  end

  // smallest shift that brings max|d| below 2^E_W
  always_comb begin
    t_next = '0;
    for (int b = E_W; b < DM_W; b++) begin
      if (mx[b]) begin
        t_next = T_W'(b - (E_W - 1));
      end
    end
  end

  // integer square root, restoring, SQ_PER result bits per stage
  always_comb begin
    logic [SUM_W-1:0] n;
    logic [REM_W-1:0] r;
    logic [R_W-1:0]   q;
    logic [REM_W-1:0] trial;
    for (int s = S_RT0; s <= S_RTN; s++) begin
      n = rt_n[s-1];
      r = rt_r[s-1];
      q = rt_q[s-1];
      for (int k = 0; k < SQ_PER; k++) begin
        if ((s - S_RT0) * SQ_PER + k < R_W) begin
          r     = {r[REM_W-3:0], n[SUM_W-1:SUM_W-2]};
          n     = n << 2;
          trial = REM_W'({q, 2'b01});
          if (r >= trial) begin
            r = r - trial;
            q = {q[R_W-2:0], 1'b1};
          end else begin
            q = {q[R_W-2:0], 1'b0};
          end
        end
      end
      rt_n_next[s] = n;
      rt_r_next[s] = r;
      rt_q_next[s] = q;
    end
  end

  // k = 6|d|*(1 - mm), capped magnitude
  always_comb begin
    logic [KC_W-1:0] ks;
    ks = KC_W'(kf >> FRAC_BITS);
    if (ks > KC_W'(srt_pkg::PROD_CAP)) begin
      kmag_next = srt_pkg::PROD_CAP;
    end else begin
      kmag_next = CAP_W'(ks);
    end
  end

  // correction term k*m_i: split partial products, then rounded and capped
  always_comb begin
    logic [M_W-1:0]   am;
    logic [CC_W-1:0]  cs;
    logic [CAP_W-1:0] cmag;
    for (int i = 0; i < 3; i++) begin
      am = m_ln[S_K][i][M_W-1] ? M_W'(-m_ln[S_K][i]) : M_W'(m_ln[S_K][i]);
      cl_next[i] = CLM_W'(kmag[KL_W-1:0]) * CLM_W'(am);
      ch_next[i] = CHM_W'(kmag[CAP_W-1:KL_W]) * CHM_W'(am);
      cs = CC_W'(cf[i] >> FRAC_BITS);
      if (cs > CC_W'(srt_pkg::PROD_CAP)) begin
        cmag = srt_pkg::PROD_CAP;
      end else begin
        cmag = CAP_W'(cs);
      end
      corr_next[i] = (kn_ln[S_CF] ^ m_ln[S_CF][i][M_W-1]) ? -CR_W'(cmag) : CR_W'(cmag);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (v[i] > srt_pkg::OUT_MAX) begin
        rate_next[i] = OUT_W'(srt_pkg::OUT_MAX);
      end else if (v[i] < srt_pkg::OUT_MIN) begin
        rate_next[i] = OUT_W'(srt_pkg::OUT_MIN);
      end else begin
        rate_next[i] = OUT_W'(v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = S_PROD; s <= S_OUT; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[S_PROD] <= accept;
      for (int s = S_PROD + 1; s <= S_OUT; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    lst[S_PROD] <= last_spin;
    for (int s = S_PROD + 1; s <= S_OUT; s++) begin
      lst[s] <= lst[s-1];
    end

    for (int i = 0; i < 3; i++) begin
      m_ln[S_PROD][i] <= m_next[i];
      h_ln[S_PROD][i] <= h_next[i];
      h_ln[S_SUM][i]  <= h_ln[S_PROD][i];
      pm[i]           <= pm_next[i];
      ph[i]           <= ph_next[i];
      p1[i]           <= p1_next[i];
      p2[i]           <= p2_next[i];
      d_ln[S_D][i]    <= D_W'(p1[i]) - D_W'(p2[i]);
      dm_ln[S_ABS][i] <= dm_next[i];
      e[i]            <= E_W'(dm_ln[S_T][i] >> t_ln[S_T]);
      sq[i]           <= e[i] * e[i];
      cl[i]           <= cl_next[i];
      ch[i]           <= ch_next[i];
      cf[i]           <= (CF_W'(ch[i]) << KL_W) + CF_W'(cl[i])
                         + (CF_W'(1) << (FRAC_BITS - 1));
      corr[i]         <= corr_next[i];
      v[i]            <= V_W'(d_ln[S_CR][i]) + V_W'(corr[i]);
    end
    for (int s = S_SUM; s <= S_CF; s++) begin
      m_ln[s] <= m_ln[s-1];
    end
    for (int s = S_D + 1; s <= S_CR; s++) begin
      d_ln[s] <= d_ln[s-1];
    end
    for (int s = S_ABS + 1; s <= S_T; s++) begin
      dm_ln[s] <= dm_ln[s-1];
    end

    mm <= MMU_W'(pm[0]) + MMU_W'(pm[1]) + MMU_W'(pm[2]);
    mh <= MH_W'(ph[0]) + MH_W'(ph[1]) + MH_W'(ph[2]);

    wm_ln[S_MUL2] <= wm_next;
    wn_ln[S_MUL2] <= wn_next;
    for (int s = S_MUL2 + 1; s <= S_C; s++) begin
      wm_ln[s] <= wm_ln[s-1];
    end
    for (int s = S_MUL2 + 1; s <= S_KF; s++) begin
      wn_ln[s] <= wn_ln[s-1];
    end

    mx01 <= (dm_ln[S_ABS][0] > dm_ln[S_ABS][1]) ? dm_ln[S_ABS][0] : dm_ln[S_ABS][1];
    mx   <= (mx01 > dm_ln[S_MX1][2]) ? mx01 : dm_ln[S_MX1][2];

    t_ln[S_T] <= t_next;
    for (int s = S_T + 1; s <= S_RTN; s++) begin
      t_ln[s] <= t_ln[s-1];
    end

    rt_n[S_SUM2] <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    rt_r[S_SUM2] <= '0;
    rt_q[S_SUM2] <= '0;
    for (int s = S_RT0; s <= S_RTN; s++) begin
      rt_n[s] <= rt_n_next[s];
      rt_r[s] <= rt_r_next[s];
      rt_q[s] <= rt_q_next[s];
    end

    norm  <= NORM_W'(rt_q[S_RTN]) << t_ln[S_RTN];
    c     <= (C_W'(norm) << 2) + (C_W'(norm) << 1);
    pk_lo <= PKL_W'(c[CL_W-1:0]) * PKL_W'(wm_ln[S_C]);
    pk_hi <= PKH_W'(c[C_W-1:CL_W]) * PKH_W'(wm_ln[S_C]);
    kf    <= (KF_W'(pk_hi) << CL_W) + KF_W'(pk_lo) + (KF_W'(1) << (FRAC_BITS - 1));
    kmag  <= kmag_next;

    kn_ln[S_K] <= wn_ln[S_KF];
    for (int s = S_K + 1; s <= S_CF; s++) begin
      kn_ln[s] <= kn_ln[s-1];
    end

    rate_x <= rate_next[0];
    rate_y <= rate_next[1];
    rate_z <= rate_next[2];
  end

  assign done     = vld[S_OUT];
  assign last_out = lst[S_OUT];

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##S_OUT (done && last_out == $past(last_spin, S_OUT)))
    else $error("result strobe missing or marker lost");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, S_OUT))
    else $error("result strobe without a request");

  a_pinned_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && pinned) |-> ##S_OUT (rate_x == '0 && rate_y == '0 && rate_z == '0))
    else $error("pinned spin gave a nonzero rate");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    vld[S_RTN] |-> (rt_r[S_RTN] <= {rt_q[S_RTN], 1'b0}))
    else $error("root remainder out of bounds");
`endif

endmodule

[dv/tb_spin_relaxation_torque.sv]
`timescale 1ns / 100ps
// Self-checking testbench for spin_relaxation_torque: directed and random spin requests,
// checked against a fixed-point torque predictor. Depends on srt_pkg and the block only.
module tb_spin_relaxation_torque;

  localparam int M_W       = srt_pkg::M_W;
  localparam int H_W       = srt_pkg::H_W;
  localparam int OUT_W     = srt_pkg::OUT_W;
  localparam int FRAC      = 16;
  localparam int QUIET_MAX = 1000;
  localparam int TAIL      = 40;
  localparam int N_RAND    = 1730;

  typedef struct {
    logic signed [M_W-1:0] mx, my, mz;
    logic signed [H_W-1:0] hx, hy, hz;
    logic                  pin, last;
    bit                    settle;
  } spin_t;

  typedef struct {
    logic [OUT_W-1:0] rx, ry, rz;
    logic             last;
  } rate_t;

  logic                    clk, rst, start, busy, done;
  logic signed [M_W-1:0]   mag_x, mag_y, mag_z;
  logic signed [H_W-1:0]   field_x, field_y, field_z;
  logic                    pinned, last_spin, last_out;
  logic signed [OUT_W-1:0] rate_x, rate_y, rate_z;

  spin_t spin_backlog[$];
  rate_t rate_due[$];
  bit    took;
  bit    gap;
  int    sent_cnt, taken_cnt, total_cnt, bad_cnt, quiet_cnt;

  spin_relaxation_torque #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .field_x(field_x), .field_y(field_y), .field_z(field_z),
    .pinned(pinned), .last_spin(last_spin),
    .done(done), .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .last_out(last_out)
  );

  // sign(a*b) * min(round-half-away(|a*b| / 2^FRAC), PROD_CAP)
  function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic [63:0]  ua, ub;
    logic [127:0] full, q;
    ua = a[63] ? ~a + 64'd1 : a;
    ub = b[63] ? ~b + 64'd1 : b;
    full = {64'd0, ua} * {64'd0, ub};
    q = (full + (128'd1 << (FRAC - 1))) >> FRAC;
    if (q > {66'd0, srt_pkg::PROD_CAP})
      q = {66'd0, srt_pkg::PROD_CAP};
    return (a[63] ^ b[63]) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic rate_t torque_of(input spin_t s);
    logic signed [63:0] m [3];
    logic signed [63:0] h [3];
    logic signed [63:0] d [3];
    logic [63:0]        da [3];
    logic [OUT_W-1:0]   rt [3];
    logic signed [63:0] mm, mh, c, k;
    logic signed [65:0] v;
    logic [63:0]        dmax, e, sq_sum, root, trial, norm;
    int                 shift;
    rate_t              r;
    r.last = s.last;
    r.rx = '0;
    r.ry = '0;
    r.rz = '0;
    if (s.pin)
      return r;
    m[0] = 64'(s.mx); m[1] = 64'(s.my); m[2] = 64'(s.mz);
    h[0] = 64'(s.hx); h[1] = 64'(s.hy); h[2] = 64'(s.hz);
    mm = 0;
    mh = 0;
    for (int i = 0; i < 3; i++) begin
      mm += scaled_mul(m[i], m[i]);
      mh += scaled_mul(m[i], h[i]);
    end
    dmax = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = scaled_mul(mm, h[i]) - scaled_mul(mh, m[i]);
      da[i] = d[i][63] ? ~d[i] + 64'd1 : d[i];
      if (da[i] > dmax)
        dmax = da[i];
    end
    // normalize so each squared term stays below 2^60
    shift = 0;
    while ((dmax >> shift) >= (64'd1 << 30))
      shift++;
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      e = da[i] >> shift;
      sq_sum += e * e;
    end
    root = 0;
    for (int bt = 30; bt >= 0; bt--) begin
      trial = root | (64'd1 << bt);
      if (trial * trial <= sq_sum)
        root = trial;
    end
    norm = root << shift;
    c = $signed(norm * 64'd6);
    k = scaled_mul(c, (64'sd1 <<< FRAC) - mm);
    for (int i = 0; i < 3; i++) begin
      v = 66'(d[i]);
      v = v + 66'(scaled_mul(k, m[i]));
      if (v > 66'(srt_pkg::OUT_MAX))
        v = 66'(srt_pkg::OUT_MAX);
      if (v < 66'(srt_pkg::OUT_MIN))
        v = 66'(srt_pkg::OUT_MIN);
      rt[i] = v[OUT_W-1:0];
    end
    r.rx = rt[0];
    r.ry = rt[1];
    r.rz = rt[2];
    return r;
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic add_spin(input int mx, input int my, input int mz,
                          input int hx, input int hy, input int hz,
                          input bit pin, input bit last);
    spin_t s;
    s.mx = M_W'(mx); s.my = M_W'(my); s.mz = M_W'(mz);
    s.hx = hx; s.hy = hy; s.hz = hz;
    s.pin = pin;
    s.last = last;
    s.settle = 0;
    spin_backlog.push_back(s);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      gap = (sent_cnt < 700 || sent_cnt >= 1000) && ($urandom_range(99) < 36);
      if (spin_backlog.size() > 0 && !gap &&
          !(spin_backlog[0].settle && rate_due.size() > 0)) begin
        mag_x     <= spin_backlog[0].mx;
        mag_y     <= spin_backlog[0].my;
        mag_z     <= spin_backlog[0].mz;
        field_x   <= spin_backlog[0].hx;
        field_y   <= spin_backlog[0].hy;
        field_z   <= spin_backlog[0].hz;
        pinned    <= spin_backlog[0].pin;
        last_spin <= spin_backlog[0].last;
        start     <= 1'b1;
        void'(spin_backlog.pop_front());
        sent_cnt++;
      end else begin
        mag_x     <= M_W'($urandom);
        mag_y     <= M_W'($urandom);
        mag_z     <= M_W'($urandom);
        field_x   <= $urandom;
        field_y   <= $urandom;
        field_z   <= $urandom;
        pinned    <= 1'($urandom);
        last_spin <= 1'($urandom);
        start     <= 1'b0;
      end
    end
  end

  // acceptance, result check and watchdog
  always @(posedge clk) begin
    spin_t s;
    rate_t want;
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        took = 1'b1;
        s.mx = mag_x; s.my = mag_y; s.mz = mag_z;
        s.hx = field_x; s.hy = field_y; s.hz = field_z;
        s.pin = pinned;
        s.last = last_spin;
        s.settle = 0;
        rate_due.push_back(torque_of(s));
        taken_cnt++;
      end
      if (done) begin
        if (rate_due.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected result: rate (%0d %0d %0d) last %0b",
                     rate_x, rate_y, rate_z, last_out);
        end else begin
          want = rate_due.pop_front();
          if (rate_x !== want.rx || rate_y !== want.ry || rate_z !== want.rz ||
              last_out !== want.last) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch: rate (%0d %0d %0d) last %0b, expected (%0d %0d %0d) last %0b",
                       rate_x, rate_y, rate_z, last_out, $signed(want.rx),
                       $signed(want.ry), $signed(want.rz), want.last);
          end
        end
      end
      if (took || done)
        quiet_cnt = 0;
      else
        quiet_cnt++;
      if (quiet_cnt >= QUIET_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    spin_t s;
    int    sel, ax, mv [3];
    rst = 1'b1;
    start = 1'b0;
    mag_x = '0; mag_y = '0; mag_z = '0;
    field_x = '0; field_y = '0; field_z = '0;
    pinned = 1'b0;
    last_spin = 1'b0;
    took = 1'b0;
    sent_cnt = 0; taken_cnt = 0; bad_cnt = 0; quiet_cnt = 0;

    add_spin(0, 0, 0, 0, 0, 0, 0, 0);
    add_spin($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 1);
    add_spin(131071, -131072, 131071, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
    add_spin(65536, 0, 0, 0, 65536, 0, 0, 0);
    add_spin(65536, 0, 0, 65536, 0, 0, 0, 1);
    add_spin(131071, 131071, 131071, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    add_spin(-131072, -131072, -131072, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    add_spin(131071, 131071, 131071, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1);
    add_spin(-131072, -131072, -131072, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    add_spin(131071, -131072, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    add_spin(-131072, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    add_spin(1, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    add_spin(46341, 46341, 0, 1000000, -2000000, 3000000, 0, 0);
    add_spin(-1, -1, -1, -1, -1, -1, 0, 1);
    add_spin(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 12345, 0, 0);
    add_spin(0, 0, 65536, 123456789, -987654321, 5, 0, 0);
    add_spin(0, -65536, 0, -70000, 0, 70000, 0, 1);
    add_spin(32768, 32768, 32768, 65536, 65536, 65536, 0, 0);
    add_spin(131071, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0);
    add_spin(0, 1, -1, 1, -1, 0, 0, 0);

    for (int n = 0; n < N_RAND; n++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        mv[0] = $urandom; mv[1] = $urandom; mv[2] = $urandom;
        s.hx = $urandom; s.hy = $urandom; s.hz = $urandom;
      end else if (sel < 70) begin
        // close to unit length along one axis
        ax = $urandom_range(2);
        for (int i = 0; i < 3; i++)
          mv[i] = span(-3000, 3000);
        mv[ax] = span(65536 - 600, 65536 + 600) * ($urandom_range(1) ? 1 : -1);
        s.hx = span(-(1 << 24), 1 << 24);
        s.hy = span(-(1 << 24), 1 << 24);
        s.hz = span(-(1 << 24), 1 << 24);
      end else begin
        for (int i = 0; i < 3; i++)
          mv[i] = span(-70000, 70000);
        s.hx = span(-(1 << 20), 1 << 20);
        s.hy = span(-(1 << 20), 1 << 20);
        s.hz = span(-(1 << 20), 1 << 20);
      end
      s.mx = M_W'(mv[0]); s.my = M_W'(mv[1]); s.mz = M_W'(mv[2]);
      s.pin = ($urandom_range(9) == 0);
      s.last = ($urandom_range(7) == 0);
      s.settle = (n == 0 || n == 900);
      spin_backlog.push_back(s);
    end
    total_cnt = spin_backlog.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (taken_cnt < total_cnt)
      @(negedge clk);
    while (rate_due.size() > 0)
      @(negedge clk);
    repeat (TAIL) @(negedge clk);

    if (bad_cnt == 0 && rate_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
